// ===== rtl/core/cbez_pkg.sv =====
`timescale 1ns / 1ps
package cbez_pkg;

   localparam int NEWTON_STEPS    = 8;
   localparam int BISECTION_STEPS = 60;
   localparam int FRAC_BITS       = 16;
   localparam int IO_SHIFT        = 30 - FRAC_BITS;

   localparam int CFG_W  = 18;
   localparam int IN_W   = 18;
   localparam int OUT_W  = 17;
   localparam int NCNT_W = $clog2(NEWTON_STEPS + 1);
   localparam int BCNT_W = $clog2(BISECTION_STEPS + 1);

   // register indexes on the csr port
   localparam logic [1:0] REG_CTRL1_X = 2'd0;
   localparam logic [1:0] REG_CTRL1_Y = 2'd1;
   localparam logic [1:0] REG_CTRL2_X = 2'd2;
   localparam logic [1:0] REG_CTRL2_Y = 2'd3;

   typedef logic signed [47:0] q_type;   // Q30 working word
   typedef logic signed [31:0] t_type;   // curve parameter, Q30 in [-2, 2)

   localparam q_type QONE     = q_type'(64'sd1 <<< 30);
   localparam q_type POLY_LIM = q_type'(64'sd1 <<< 40);
   localparam q_type ERR_LIM  = q_type'(64'sd1 <<< 32);

   typedef enum logic [3:0] {
      S_IDLE, S_COEF0, S_COEF1, S_MUL_LO, S_MUL_HI, S_ADD,
      S_DCHK, S_DRUN, S_NUPD, S_BINIT, S_BCHK, S_OUT
   } state_type;

   typedef enum logic [1:0] {
      PH_NCURVE, PH_NSLOPE, PH_BCURVE, PH_YCURVE
   } phase_type;

   function automatic q_type psat(q_type v);
      if (v > POLY_LIM) return POLY_LIM;
      if (v < -POLY_LIM) return -POLY_LIM;
      return v;
   endfunction

   function automatic logic [47:0] mag48(q_type v);
      return (v < 0) ? 48'(-v) : 48'(v);
   endfunction

   function automatic q_type times3(q_type v);
      return v + (v <<< 1);
   endfunction

endpackage

// ===== rtl/core/cubic_bezier_easing_solver_core.sv =====
`timescale 1ns / 1ps
// Cubic-bezier easing core: maps a progress word to an eased value on the
// curve from (0,0) to (1,1) through two control points.
// Channels: req_ takes one progress word (signed Q2.16), rsp_ returns one
// eased word (unsigned Q16, 65536 = 1.0) for each request, in order.
// The csr_ port writes the four control point coordinates (signed Q2.16);
// write only while the core is idle.
// Progress at or below 0, at or above 1, or a diagonal curve gives a
// result on the cycle after acceptance. Otherwise the coefficients are
// set up first, then per Newton step x(t), x'(t) and the quotient (up to
// 8 steps), then up to 60 bisection steps, then y(t); the work runs on
// the one shared 42x16 multiplier and the bit-serial divider.
// Throughput: one word at a time; req_tready is high only while idle.
// Reset: synchronous, active high; control points return to the linear
// curve (0,0),(1,1) and any word in flight is dropped.
// Stall: a result holds on rsp_tdata until rsp_tready takes it.
module cubic_bezier_easing_solver_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [17:0] progress
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [16:0] eased_value
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [17:0] csr_wdata
);
   import cbez_pkg::*;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;

   logic signed [CFG_W-1:0] c1x_ff, c1y_ff, c2x_ff, c2y_ff;

   q_type cx0_ff, cx1_ff, cx2_ff, cy0_ff, cy1_ff, cy2_ff;
   q_type cx0_in, cx1_in, cx2_in, cy0_in, cy1_in, cy2_in;
   q_type acc_ff, acc_in, err_ff, err_in, d_ff, d_in;
   t_type t_ff, t_in, pin_ff, pin_in, lo_ff, lo_in, hi_ff, hi_in;
   logic [57:0] prod_ff, prod_in;
   logic        mneg_ff, mneg_in, qneg_ff, qneg_in;
   logic [1:0]  hidx_ff, hidx_in;
   logic [NCNT_W-1:0] ncnt_ff, ncnt_in;
   logic [BCNT_W-1:0] bcnt_ff, bcnt_in;
   logic [5:0]  dcnt_ff, dcnt_in;
   logic [40:0] rem_ff, rem_in, dmag_ff, dmag_in;
   logic [33:0] numlo_ff, numlo_in, q_ff, q_in;
   logic [OUT_W-1:0] eased_ff, eased_in;

   // shared multiplier
   logic [47:0] amag;
   logic [31:0] tmag;
   logic [15:0] mul_b;
   logic [57:0] mul_out;

   // combinational helpers
   q_type s_p1x, s_p2x, s_p1y, s_p2y, r_val, v_val, addend, errv, esat, ycl;
   logic [47:0] emag;
   logic [41:0] trial;
   logic        last_step;
   logic signed [35:0] qs;
   logic signed [36:0] tn;
   logic [33:0] qeff;
   t_type lo_n, hi_n;
   logic signed [IN_W-1:0] prog;

   assign prog = req_tdata[IN_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         c1x_ff <= '0;
         c1y_ff <= '0;
         c2x_ff <= 18'sd65536;
         c2y_ff <= 18'sd65536;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_CTRL1_X: c1x_ff <= csr_wdata;
            REG_CTRL1_Y: c1y_ff <= csr_wdata;
            REG_CTRL2_X: c2x_ff <= csr_wdata;
            REG_CTRL2_Y: c2y_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_NCURVE;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      cx0_ff <= cx0_in;  cx1_ff <= cx1_in;  cx2_ff <= cx2_in;
      cy0_ff <= cy0_in;  cy1_ff <= cy1_in;  cy2_ff <= cy2_in;
      acc_ff <= acc_in;  err_ff <= err_in;  d_ff <= d_in;
      t_ff <= t_in;      pin_ff <= pin_in;  lo_ff <= lo_in;  hi_ff <= hi_in;
      prod_ff <= prod_in;
      mneg_ff <= mneg_in; qneg_ff <= qneg_in;
      hidx_ff <= hidx_in; ncnt_ff <= ncnt_in; bcnt_ff <= bcnt_in;
      dcnt_ff <= dcnt_in;
      rem_ff <= rem_in;  dmag_ff <= dmag_in;
      numlo_ff <= numlo_in; q_ff <= q_in;
      eased_ff <= eased_in;
   end

   always_comb begin
      amag    = mag48(acc_ff);
      tmag    = (t_ff < 0) ? 32'(-t_ff) : 32'(t_ff);
      mul_b   = (state_ff == S_MUL_LO) ? tmag[15:0] : tmag[31:16];
      mul_out = amag[41:0] * mul_b;
   end

   always_comb begin
      state_in = state_ff;  phase_in = phase_ff;
      cx0_in = cx0_ff;  cx1_in = cx1_ff;  cx2_in = cx2_ff;
      cy0_in = cy0_ff;  cy1_in = cy1_ff;  cy2_in = cy2_ff;
      acc_in = acc_ff;  err_in = err_ff;  d_in = d_ff;
      t_in = t_ff;  pin_in = pin_ff;  lo_in = lo_ff;  hi_in = hi_ff;
      prod_in = prod_ff;  mneg_in = mneg_ff;  qneg_in = qneg_ff;
      hidx_in = hidx_ff;  ncnt_in = ncnt_ff;  bcnt_in = bcnt_ff;
      dcnt_in = dcnt_ff;  rem_in = rem_ff;  dmag_in = dmag_ff;
      numlo_in = numlo_ff;  q_in = q_ff;  eased_in = eased_ff;

      s_p1x = q_type'(c1x_ff) <<< 14;
      s_p2x = q_type'(c2x_ff) <<< 14;
      s_p1y = q_type'(c1y_ff) <<< 14;
      s_p2y = q_type'(c2y_ff) <<< 14;

      r_val = q_type'(prod_ff >> 14);
      if (mneg_ff) r_val = -r_val;
      unique case (phase_ff)
         PH_NSLOPE: addend = (hidx_ff == 2'd0) ? (cx1_ff <<< 1) : cx0_ff;
         PH_YCURVE: addend = (hidx_ff == 2'd0) ? cy1_ff :
                             (hidx_ff == 2'd1) ? cy0_ff : '0;
         default:   addend = (hidx_ff == 2'd0) ? cx1_ff :
                             (hidx_ff == 2'd1) ? cx0_ff : '0;
      endcase
      v_val     = psat(r_val + addend);
      last_step = (phase_ff == PH_NSLOPE) ? (hidx_ff == 2'd1) : (hidx_ff == 2'd2);
      errv      = v_val - q_type'(pin_ff);

      esat  = (err_ff > ERR_LIM) ? ERR_LIM : ((err_ff < -ERR_LIM) ? -ERR_LIM : err_ff);
      emag  = mag48(esat);
      trial = {rem_ff, numlo_ff[33]};

      qeff = (q_ff > 34'(64'd1 << 33)) ? 34'(64'd1 << 33) : q_ff;
      qs   = qneg_ff ? -36'(signed'({2'b00, qeff})) : 36'(signed'({2'b00, qeff}));
      tn   = 37'(t_ff) - 37'(qs);

      lo_n = (q_type'(pin_ff) > v_val) ? t_ff : lo_ff;
      hi_n = (q_type'(pin_ff) > v_val) ? hi_ff : t_ff;

      ycl = (v_val < 0) ? '0 : ((v_val > QONE) ? QONE : v_val);

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (prog <= 0) begin
                  eased_in = '0;
                  state_in = S_OUT;
               end else if (prog >= IN_W'(1 << FRAC_BITS)) begin
                  eased_in = OUT_W'(1 << FRAC_BITS);
                  state_in = S_OUT;
               end else if (c1x_ff == c1y_ff && c2x_ff == c2y_ff) begin
                  eased_in = OUT_W'(prog);
                  state_in = S_OUT;
               end else begin
                  pin_in   = t_type'(prog) <<< IO_SHIFT;
                  state_in = S_COEF0;
               end
            end
         end
         S_COEF0: begin
            cx0_in = times3(s_p1x);
            cx1_in = times3(s_p2x - s_p1x) - times3(s_p1x);
            cy0_in = times3(s_p1y);
            cy1_in = times3(s_p2y - s_p1y) - times3(s_p1y);
            state_in = S_COEF1;
         end
         S_COEF1: begin
            cx2_in = QONE - cx0_ff - cx1_ff;
            cy2_in = QONE - cy0_ff - cy1_ff;
            acc_in = QONE - cx0_ff - cx1_ff;
            t_in = pin_ff;  ncnt_in = '0;  hidx_in = '0;
            phase_in = PH_NCURVE;
            state_in = S_MUL_LO;
         end
         S_MUL_LO: begin
            prod_in  = mul_out;
            mneg_in  = (acc_ff < 0) != (t_ff < 0);
            state_in = S_MUL_HI;
         end
         S_MUL_HI: begin
            prod_in  = mul_out + (prod_ff >> 16);
            state_in = S_ADD;
         end
         S_ADD: begin
            acc_in  = v_val;
            hidx_in = hidx_ff + 2'd1;
            if (!last_step) begin
               state_in = S_MUL_LO;
            end else begin
               hidx_in = '0;
               unique case (phase_ff)
                  PH_NCURVE: begin
                     if (errv == 0) begin
                        acc_in = cy2_ff;  phase_in = PH_YCURVE;  state_in = S_MUL_LO;
                     end else begin
                        err_in = errv;
                        acc_in = times3(cx2_ff);
                        phase_in = PH_NSLOPE;  state_in = S_MUL_LO;
                     end
                  end
                  PH_NSLOPE: begin
                     if (v_val == 0) begin
                        state_in = S_BINIT;
                     end else begin
                        d_in = v_val;  state_in = S_DCHK;
                     end
                  end
                  PH_BCURVE: begin
                     if (v_val == q_type'(pin_ff)) begin
                        acc_in = cy2_ff;  phase_in = PH_YCURVE;  state_in = S_MUL_LO;
                     end else begin
                        lo_in = lo_n;  hi_in = hi_n;
                        t_in  = t_type'((33'(lo_n) + 33'(hi_n)) >>> 1);
                        bcnt_in  = bcnt_ff + 1'b1;
                        state_in = S_BCHK;
                     end
                  end
                  PH_YCURVE: begin
                     eased_in = OUT_W'((ycl + q_type'(1 << (IO_SHIFT - 1))) >>> IO_SHIFT);
                     state_in = S_OUT;
                  end
                  default: ;
               endcase
            end
         end
         S_DCHK: begin
            dmag_in = 41'(mag48(d_ff));
            qneg_in = (err_ff < 0) != (d_ff < 0);
            q_in    = '0;
            if ((emag >> 4) >= 48'(mag48(d_ff))) begin
               q_in = 34'(64'd1 << 33);
               state_in = S_NUPD;
            end else begin
               rem_in   = 41'(emag >> 4);
               numlo_in = {emag[3:0], 30'd0};
               dcnt_in  = '0;
               state_in = S_DRUN;
            end
         end
         S_DRUN: begin
            if (trial >= {1'b0, dmag_ff}) begin
               rem_in = 41'(trial - {1'b0, dmag_ff});
               q_in   = {q_ff[32:0], 1'b1};
            end else begin
               rem_in = trial[40:0];
               q_in   = {q_ff[32:0], 1'b0};
            end
            numlo_in = {numlo_ff[32:0], 1'b0};
            dcnt_in  = dcnt_ff + 6'd1;
            if (dcnt_ff == 6'd33) state_in = S_NUPD;
         end
         S_NUPD: begin
            if (tn > 37'sh7FFFFFFF)       t_in = 32'sh7FFFFFFF;
            else if (tn < -37'sh80000000) t_in = 32'sh80000000;
            else                          t_in = tn[31:0];
            ncnt_in = ncnt_ff + 1'b1;
            if (ncnt_ff == NCNT_W'(NEWTON_STEPS - 1)) begin
               state_in = S_BINIT;
            end else begin
               acc_in = cx2_ff;  phase_in = PH_NCURVE;  state_in = S_MUL_LO;
            end
         end
         S_BINIT: begin
            t_in = pin_ff;  lo_in = '0;  hi_in = t_type'(QONE);  bcnt_in = '0;
            state_in = S_BCHK;
         end
         S_BCHK: begin
            if (bcnt_ff < BCNT_W'(BISECTION_STEPS) && lo_ff < hi_ff) begin
               acc_in = cx2_ff;  phase_in = PH_BCURVE;
            end else begin
               acc_in = cy2_ff;  phase_in = PH_YCURVE;
            end
            state_in = S_MUL_LO;
         end
         S_OUT: begin
            if (rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = {7'd0, eased_ff};

   a_nonpos_zero: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && prog <= 0) |=> (rsp_tvalid && eased_ff == '0))
      else $error("non-positive progress must give zero");

   a_bis_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL_LO && phase_ff == PH_BCURVE) |-> (t_ff >= 0 && t_ff <= QONE))
      else $error("bisection parameter left [0,1]");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DRUN) |-> (rem_ff < dmag_ff))
      else $error("divider remainder not below divisor");

   a_out_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (eased_ff <= OUT_W'(1 << FRAC_BITS)))
      else $error("eased value above one");

endmodule
